// ----- sv/rre_pkg.sv -----
package rre_pkg;

    localparam int TIME_BITS = 40;
    localparam int SAMPLE_W  = 32;
    localparam int MAG_W     = 31;
    localparam int Q3_W      = 34;
    localparam int RTO_W     = 20;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam int IN_BITS   = SAMPLE_W + TIME_BITS;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = RTO_W + 2 * Q3_W + 2 * MAG_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    // RTO in ms is (srtt + 4*rttvar) / 8000 in Q3 us, done as a shift by 6 and a
    // divide by 125 through a reciprocal multiply with one correction step.
    localparam int          PRESCALE_SHIFT = 6;
    localparam int          SCALED_W       = Q3_W + 3 - PRESCALE_SHIFT;
    localparam int          RECIP_SHIFT    = 38;
    localparam logic [31:0] RECIP_125      = 32'd2199023255;
    localparam int          PROD_W         = SCALED_W + 32;
    localparam int          QUOT_W         = PROD_W - RECIP_SHIFT;
    localparam int          REM_W          = SCALED_W + 1;
    localparam int          RTO_DIVISOR    = 125;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RTO_MIN       = 2'd0,
        CFG_RTO_MAX       = 2'd1,
        CFG_MIN_TRACK_WIN = 2'd2,
        CFG_QUEUE_FLOOR   = 2'd3
    } cfg_index_t;

    localparam logic [RTO_W-1:0] RTO_MIN_RESET     = 20'd200;
    localparam logic [RTO_W-1:0] RTO_MAX_RESET     = 20'd60000;
    localparam logic [CFG_W-1:0] MIN_TRACK_RESET   = 32'd10000000;
    localparam logic [CFG_W-1:0] QUEUE_FLOOR_RESET = 32'd20000;

    typedef struct packed {
        logic             seeded;
        logic [Q3_W-1:0]  srtt;
        logic [Q3_W-1:0]  rttvar;
        logic [MAG_W-1:0] min_rtt;
        logic [MAG_W-1:0] window_min;
    } est_t;

    typedef struct packed {
        logic [RTO_W-1:0] rto;
        est_t             est;
    } result_t;

endpackage

// ----- sv/rtt_rto_estimator.sv -----
// A word passes the input register, the state registers, the timeout divide and the result
// buffer. Throughput: one word per cycle while s_tready is high; the state update is one
// registered step, so samples go back to back. Three divide stages follow the state registers.
// An eight-entry result buffer parts the sides; s_tready drops only when eight words are
// in flight. Reset (aresetn low, synchronous) clears the estimator, buffer and
// counters and loads the default bounds and windows.
module rtt_rto_estimator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rre_pkg::IN_W-1:0]      s_tdata,   // sample_us, now_us
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rre_pkg::OUT_W-1:0]     m_tdata,   // rto_ms, srtt_q3_us, rttvar_q3_us,
                                                     // min_rtt_us, window_min_us
    output logic [0:0]                    m_tuser,   // has_estimate
    input  logic                          cfg_wr_en,
    input  logic [rre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rre_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int TB = rre_pkg::TIME_BITS;
    localparam int QW = rre_pkg::Q3_W;
    localparam int MW = rre_pkg::MAG_W;
    localparam int NEED_W = QW - 1;

    logic [rre_pkg::RTO_W-1:0] rto_min_reg;
    logic [rre_pkg::RTO_W-1:0] rto_max_reg;
    logic [rre_pkg::CFG_W-1:0] min_win_reg;
    logic [rre_pkg::CFG_W-1:0] floor_reg;

    logic                              in_valid_reg;
    logic signed [rre_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic [TB-1:0]                     in_now_reg;

    logic          seeded_reg, seeded_next;
    logic [QW-1:0] srtt_reg, srtt_next;
    logic [QW-1:0] rttvar_reg, rttvar_next;
    logic [MW-1:0] lowest_reg, lowest_next;
    logic [TB-1:0] lowest_time_reg, lowest_time_next;
    logic [MW-1:0] gather_reg, gather_next;
    logic [MW-1:0] closed_reg, closed_next;
    logic [TB-1:0] open_time_reg, open_time_next;

    logic st_valid_reg;
    logic st_upd_reg;

    logic                           p2_valid_reg;
    logic                           p2_upd_reg;
    rre_pkg::est_t                  p2_est_reg;
    logic [rre_pkg::SCALED_W-1:0]   p2_scaled_reg;

    logic                           p3_valid_reg;
    logic                           p3_upd_reg;
    rre_pkg::est_t                  p3_est_reg;
    logic [rre_pkg::SCALED_W-1:0]   p3_scaled_reg;
    logic [rre_pkg::PROD_W-1:0]     p3_prod_reg;

    logic [rre_pkg::RTO_W-1:0] timeout_reg;

    rre_pkg::result_t           fifo_mem_reg [rre_pkg::FIFO_DEPTH];
    logic [rre_pkg::PTR_W-1:0]  wr_ptr_reg;
    logic [rre_pkg::PTR_W-1:0]  rd_ptr_reg;
    logic [rre_pkg::CNT_W-1:0]  fifo_cnt_reg;
    logic [rre_pkg::CNT_W-1:0]  inflight_reg;

    logic s_acc;
    logic m_acc;
    logic sample_ok;

    logic [MW-1:0]     sample_mag;
    logic [QW-1:0]     sample_q3;
    logic [TB-1:0]     age;
    logic              stale;
    logic              replace_min;
    logic [QW-1:0]     diff;
    logic [QW+2:0]     dev_sum;
    logic [QW+3:0]     srtt_sum;
    logic [QW-1:0]     rttvar_upd;
    logic [QW-1:0]     srtt_upd;
    logic [QW:0]       need_round;
    logic [NEED_W-1:0] need_q;
    logic [NEED_W-1:0] floor_ext;
    logic [NEED_W-1:0] need;
    logic [TB-1:0]     elapsed;
    logic              window_close;

    logic [QW+2:0]                 scale_sum;
    logic [rre_pkg::QUOT_W-1:0]    quot0;
    logic [rre_pkg::REM_W-1:0]     quot0_x125;
    logic [rre_pkg::REM_W-1:0]     remainder;
    logic [rre_pkg::QUOT_W-1:0]    quot;
    logic [rre_pkg::QUOT_W-1:0]    low_clamped;
    logic [rre_pkg::RTO_W-1:0]     rto_clamped;
    logic [rre_pkg::RTO_W-1:0]     rto_out;
    rre_pkg::result_t              head;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = inflight_reg < rre_pkg::CNT_W'(rre_pkg::FIFO_DEPTH);
    assign m_tvalid = fifo_cnt_reg != '0;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rto_min_reg <= rre_pkg::RTO_MIN_RESET;
            rto_max_reg <= rre_pkg::RTO_MAX_RESET;
            min_win_reg <= rre_pkg::MIN_TRACK_RESET;
            floor_reg   <= rre_pkg::QUEUE_FLOOR_RESET;
        end else if (cfg_wr_en) begin
            case (rre_pkg::cfg_index_t'(cfg_index))
                rre_pkg::CFG_RTO_MIN:       rto_min_reg <= cfg_wdata[rre_pkg::RTO_W-1:0];
                rre_pkg::CFG_RTO_MAX:       rto_max_reg <= cfg_wdata[rre_pkg::RTO_W-1:0];
                rre_pkg::CFG_MIN_TRACK_WIN: min_win_reg <= cfg_wdata;
                rre_pkg::CFG_QUEUE_FLOOR:   floor_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_acc;
        end
        if (s_acc) begin
            in_sample_reg <= s_tdata[rre_pkg::SAMPLE_W-1:0];
            in_now_reg    <= s_tdata[rre_pkg::SAMPLE_W +: TB];
        end
    end

    // Estimator update.
    assign sample_ok   = !in_sample_reg[rre_pkg::SAMPLE_W-1];
    assign sample_mag  = in_sample_reg[MW-1:0];
    assign sample_q3   = {sample_mag, 3'b000};
    assign age         = in_now_reg - lowest_time_reg;
    assign stale       = age > TB'(min_win_reg);
    assign replace_min = (sample_mag < lowest_reg) || (lowest_reg == '0) || stale;

    assign diff = (srtt_reg > sample_q3) ? (srtt_reg - sample_q3) : (sample_q3 - srtt_reg);
    assign dev_sum    = (QW+3)'({rttvar_reg, 1'b0}) + (QW+3)'(rttvar_reg) + (QW+3)'(diff);
    assign rttvar_upd = dev_sum[QW+1:2];
    assign srtt_sum   = (QW+4)'({srtt_reg, 3'b000}) - (QW+4)'(srtt_reg) + (QW+4)'(sample_q3);
    assign srtt_upd   = srtt_sum[QW+2:3];

    // Window length is max(ceil(srtt_q3 / 4), floor), that is twice srtt rounded up, in whole microseconds.
    assign need_round   = (QW+1)'(srtt_upd) + (QW+1)'(3);
    assign need_q       = need_round[QW:2];
    assign floor_ext    = NEED_W'(floor_reg);
    assign need         = (need_q > floor_ext) ? need_q : floor_ext;
    assign elapsed      = in_now_reg - open_time_reg;
    assign window_close = elapsed >= TB'(need);

    always_comb begin
        seeded_next      = seeded_reg;
        srtt_next        = srtt_reg;
        rttvar_next      = rttvar_reg;
        lowest_next      = lowest_reg;
        lowest_time_next = lowest_time_reg;
        gather_next      = gather_reg;
        closed_next      = closed_reg;
        open_time_next   = open_time_reg;
        if (in_valid_reg && sample_ok) begin
            if (!seeded_reg) begin
                seeded_next      = 1'b1;
                srtt_next        = sample_q3;
                rttvar_next      = QW'({sample_mag, 2'b00});
                lowest_next      = sample_mag;
                lowest_time_next = in_now_reg;
                gather_next      = sample_mag;
                open_time_next   = in_now_reg;
            end else begin
                if (replace_min) begin
                    lowest_next      = sample_mag;
                    lowest_time_next = in_now_reg;
                end
                rttvar_next = rttvar_upd;
                srtt_next   = srtt_upd;
                if (window_close) begin
                    closed_next    = gather_reg;
                    gather_next    = sample_mag;
                    open_time_next = in_now_reg;
                end else if (sample_mag < gather_reg) begin
                    gather_next = sample_mag;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg      <= 1'b0;
            srtt_reg        <= '0;
            rttvar_reg      <= '0;
            lowest_reg      <= '0;
            lowest_time_reg <= '0;
            gather_reg      <= '0;
            closed_reg      <= '0;
            open_time_reg   <= '0;
            st_valid_reg    <= 1'b0;
        end else begin
            seeded_reg      <= seeded_next;
            srtt_reg        <= srtt_next;
            rttvar_reg      <= rttvar_next;
            lowest_reg      <= lowest_next;
            lowest_time_reg <= lowest_time_next;
            gather_reg      <= gather_next;
            closed_reg      <= closed_next;
            open_time_reg   <= open_time_next;
            st_valid_reg    <= in_valid_reg;
        end
        st_upd_reg <= sample_ok;
    end

    // Timeout path: prescale, reciprocal multiply, correct and clamp.
    assign scale_sum = (QW+3)'(srtt_reg) + (QW+3)'({rttvar_reg, 2'b00});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= st_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
        p2_upd_reg            <= st_upd_reg;
        p2_est_reg.seeded     <= seeded_reg;
        p2_est_reg.srtt       <= srtt_reg;
        p2_est_reg.rttvar     <= rttvar_reg;
        p2_est_reg.min_rtt    <= lowest_reg;
        p2_est_reg.window_min <= closed_reg;
        p2_scaled_reg         <= scale_sum[QW+2:rre_pkg::PRESCALE_SHIFT];

        p3_upd_reg    <= p2_upd_reg;
        p3_est_reg    <= p2_est_reg;
        p3_scaled_reg <= p2_scaled_reg;
        p3_prod_reg   <= rre_pkg::PROD_W'(p2_scaled_reg) *
                         rre_pkg::PROD_W'(rre_pkg::RECIP_125);
    end

    // The reciprocal estimate is at most one low, so one compare fixes it.
    assign quot0      = p3_prod_reg[rre_pkg::PROD_W-1:rre_pkg::RECIP_SHIFT];
    assign quot0_x125 = rre_pkg::REM_W'({quot0, 7'b0000000}) -
                        rre_pkg::REM_W'({quot0, 1'b0}) - rre_pkg::REM_W'(quot0);
    assign remainder  = rre_pkg::REM_W'(p3_scaled_reg) - quot0_x125;
    assign quot       = quot0 +
                        rre_pkg::QUOT_W'(remainder >= rre_pkg::REM_W'(rre_pkg::RTO_DIVISOR));
    assign low_clamped = (quot < rre_pkg::QUOT_W'(rto_min_reg)) ?
                         rre_pkg::QUOT_W'(rto_min_reg) : quot;
    assign rto_clamped = (low_clamped > rre_pkg::QUOT_W'(rto_max_reg)) ?
                         rto_max_reg : low_clamped[rre_pkg::RTO_W-1:0];
    assign rto_out     = p3_upd_reg ? rto_clamped : timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= '0;
        end else if (p3_valid_reg) begin
            timeout_reg <= rto_out;
        end
    end

    // Result buffer and in-flight word count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            inflight_reg <= '0;
        end else begin
            if (p3_valid_reg) begin
                wr_ptr_reg <= wr_ptr_reg + rre_pkg::PTR_W'(1);
            end
            if (m_acc) begin
                rd_ptr_reg <= rd_ptr_reg + rre_pkg::PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + rre_pkg::CNT_W'(p3_valid_reg)
                                         - rre_pkg::CNT_W'(m_acc);
            inflight_reg <= inflight_reg + rre_pkg::CNT_W'(s_acc)
                                         - rre_pkg::CNT_W'(m_acc);
        end
        if (p3_valid_reg) begin
            fifo_mem_reg[wr_ptr_reg].rto <= rto_out;
            fifo_mem_reg[wr_ptr_reg].est <= p3_est_reg;
        end
    end

    assign head    = fifo_mem_reg[rd_ptr_reg];
    assign m_tdata = rre_pkg::OUT_W'({head.est.window_min, head.est.min_rtt,
                                      head.est.rttvar, head.est.srtt, head.rto});
    assign m_tuser = head.est.seeded;

    assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= rre_pkg::CNT_W'(rre_pkg::FIFO_DEPTH))
        else $error("More words in flight than the result buffer holds.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= inflight_reg)
        else $error("Result buffer holds a word that was never accepted.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        seeded_reg |=> seeded_reg)
        else $error("Estimator lost its seed without a reset.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !sample_ok) |=>
            ($stable(srtt_reg) && $stable(rttvar_reg) && $stable(lowest_reg) &&
             $stable(closed_reg) && $stable(gather_reg)))
        else $error("A negative sample changed the estimator state.");

endmodule
